### hw/rtl/pps_pkg.sv
// shared types and constants of the preemptive priority scheduler
// no dependencies; used by pps_ctrl, pps_dpath and the top level
`default_nettype none

package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int ID_W = 8;
  localparam int ARR_W = 16;
  localparam int BURST_W = 16;
  localparam int PRI_W = 8;
  localparam int TIME_W = 21;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TIME_W-1:0]  tim_t;
  typedef logic [BURST_W-1:0] burst_t;

  // command codes of the input item
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic               command;
    logic [ID_W-1:0]    task_id;
    logic [ARR_W-1:0]   arrival_time;
    logic [BURST_W-1:0] burst_length;
    logic [PRI_W-1:0]   priority_level;
  } pps_in_t;

  typedef struct packed {
    logic [ID_W-1:0]   done_id;
    logic [TIME_W-1:0] first_start;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] wait_time;
    logic              last;
  } pps_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic run_init;
    logic scan_step;
    logic exec;
    logic emit;
  } pps_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic found;
    logic finish;
    logic has_future;
    logic out_free;
    logic last_rec;
  } pps_sts_t;

endpackage

`default_nettype wire

### hw/rtl/pps_ctrl.sv
// controller state machine of the preemptive priority scheduler
// depends on pps_pkg
`default_nettype none

module pps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              command,
  input  wire pps_pkg::pps_sts_t sts,
  output logic                   in_ready,
  output pps_pkg::pps_ctl_t      ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          if (command == pps_pkg::CMD_RUN) begin
            if (!sts.count_zero) begin
              ctl.run_init = 1'b1;
              state_nxt    = S_SCAN;
            end
          end else begin
            ctl.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = sts.finish ? S_FIN : S_SCAN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = sts.last_rec ? S_IDLE : S_SCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pps_dpath.sv
// datapath of the preemptive priority scheduler: task table, scan, clock, result register
// depends on pps_pkg
`default_nettype none

module pps_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pps_pkg::pps_in_t  in_data,
  input  wire pps_pkg::pps_ctl_t ctl,
  input  wire logic              out_ready,
  output pps_pkg::pps_sts_t      sts,
  output logic                   out_valid,
  output pps_pkg::pps_out_t      out_data
);

  // task table
  logic [pps_pkg::ID_W-1:0]    id_r    [pps_pkg::MAX_TASKS];
  logic [pps_pkg::ARR_W-1:0]   arr_r   [pps_pkg::MAX_TASKS];
  logic [pps_pkg::BURST_W-1:0] burst_r [pps_pkg::MAX_TASKS];
  logic [pps_pkg::PRI_W-1:0]   pri_r   [pps_pkg::MAX_TASKS];
  logic [pps_pkg::BURST_W-1:0] rem_r   [pps_pkg::MAX_TASKS];
  pps_pkg::tim_t               first_r [pps_pkg::MAX_TASKS];
  logic [pps_pkg::MAX_TASKS-1:0] started_r;
  logic [pps_pkg::MAX_TASKS-1:0] done_r;

  pps_pkg::cnt_t count_r;
  pps_pkg::cnt_t fin_cnt_r;
  pps_pkg::tim_t time_r;
  pps_pkg::idx_t idx_r;

  // best candidate of the current scan
  logic                        best_vld_r;
  pps_pkg::idx_t               best_idx_r;
  logic [pps_pkg::ID_W-1:0]    best_id_r;
  logic [pps_pkg::ARR_W-1:0]   best_arr_r;
  logic [pps_pkg::BURST_W-1:0] best_burst_r;
  logic [pps_pkg::PRI_W-1:0]   best_pri_r;
  logic [pps_pkg::BURST_W-1:0] best_rem_r;
  pps_pkg::tim_t               best_first_r;
  logic                        best_started_r;

  // earliest pending arrival of the current scan
  logic                        fut_vld_r;
  logic [pps_pkg::ARR_W-1:0]   fut_min_r;

  logic              out_valid_r;
  pps_pkg::pps_out_t out_data_r;

  logic                        load_ok;
  pps_pkg::idx_t               wr_idx;
  logic [pps_pkg::ID_W-1:0]    rd_id;
  logic [pps_pkg::ARR_W-1:0]   rd_arr;
  logic [pps_pkg::PRI_W-1:0]   rd_pri;
  logic                        rd_done;
  logic                        is_ready;
  logic                        is_future;
  logic                        better;
  logic [pps_pkg::ARR_W-1:0]   gap;
  logic [pps_pkg::BURST_W-1:0] slice;
  logic [pps_pkg::BURST_W-1:0] rem_left;
  pps_pkg::tim_t               time_plus;
  pps_pkg::tim_t               tat;
  pps_pkg::tim_t               wt;
  pps_pkg::cnt_t               fin_plus;

  assign load_ok = ctl.load && (count_r < pps_pkg::cnt_t'(pps_pkg::MAX_TASKS));
  assign wr_idx  = count_r[pps_pkg::IDX_W-1:0];

  assign rd_id   = id_r[idx_r];
  assign rd_arr  = arr_r[idx_r];
  assign rd_pri  = pri_r[idx_r];
  assign rd_done = done_r[idx_r];

  assign is_ready  = !rd_done && (pps_pkg::tim_t'(rd_arr) <= time_r);
  assign is_future = !rd_done && (pps_pkg::tim_t'(rd_arr) > time_r);

  // priority, then arrival, then id; equal keys keep the earlier slot
  assign better = !best_vld_r
               || (rd_pri < best_pri_r)
               || ((rd_pri == best_pri_r) && (rd_arr < best_arr_r))
               || ((rd_pri == best_pri_r) && (rd_arr == best_arr_r) && (rd_id < best_id_r));

  // run until completion or the next arrival
  assign gap       = pps_pkg::ARR_W'(pps_pkg::tim_t'(fut_min_r) - time_r);
  assign slice     = (fut_vld_r && (gap < best_rem_r)) ? gap : best_rem_r;
  assign rem_left  = best_rem_r - slice;
  assign time_plus = time_r + pps_pkg::tim_t'(slice);

  assign tat      = time_r - pps_pkg::tim_t'(best_arr_r);
  assign wt       = tat - pps_pkg::tim_t'(best_burst_r);
  assign fin_plus = fin_cnt_r + pps_pkg::cnt_t'(1);

  always_comb begin
    sts            = '0;
    sts.count_zero = (count_r == '0);
    sts.scan_last  = (idx_r == pps_pkg::idx_t'(count_r - pps_pkg::cnt_t'(1)));
    sts.found      = best_vld_r;
    sts.finish     = best_vld_r && (slice == best_rem_r);
    sts.has_future = fut_vld_r;
    sts.out_free   = !out_valid_r || out_ready;
    sts.last_rec   = (fin_plus == count_r);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fin_cnt_r   <= '0;
      time_r      <= '0;
      idx_r       <= '0;
      best_vld_r  <= 1'b0;
      fut_vld_r   <= 1'b0;
      started_r   <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new record replaces one leaving in the same cycle
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load_ok) begin
        count_r           <= count_r + pps_pkg::cnt_t'(1);
        started_r[wr_idx] <= 1'b0;
      end
      if (ctl.run_init) begin
        time_r     <= '0;
        done_r     <= '0;
        fin_cnt_r  <= '0;
        idx_r      <= '0;
        best_vld_r <= 1'b0;
        fut_vld_r  <= 1'b0;
      end
      if (ctl.scan_step) begin
        idx_r <= idx_r + pps_pkg::idx_t'(1);
        if (is_ready && better) begin
          best_vld_r <= 1'b1;
        end
        if (is_future && (!fut_vld_r || (rd_arr < fut_min_r))) begin
          fut_vld_r <= 1'b1;
        end
      end
      if (ctl.exec) begin
        idx_r      <= '0;
        best_vld_r <= 1'b0;
        fut_vld_r  <= 1'b0;
        if (best_vld_r) begin
          time_r <= time_plus;
          if (!best_started_r) begin
            started_r[best_idx_r] <= 1'b1;
          end
        end else begin
          time_r <= pps_pkg::tim_t'(fut_min_r);
        end
      end
      if (ctl.emit) begin
        done_r[best_idx_r] <= 1'b1;
        fin_cnt_r          <= fin_plus;
        if (sts.last_rec) begin
          count_r   <= '0;
          started_r <= '0;
        end
      end
    end
  end

  // payload: table entries, candidate fields and result register
  always_ff @(posedge clk) begin
    if (load_ok) begin
      id_r[wr_idx]    <= in_data.task_id;
      arr_r[wr_idx]   <= in_data.arrival_time;
      burst_r[wr_idx] <= in_data.burst_length;
      pri_r[wr_idx]   <= in_data.priority_level;
      rem_r[wr_idx]   <= in_data.burst_length;
      first_r[wr_idx] <= '0;
    end
    if (ctl.scan_step) begin
      if (is_ready && better) begin
        best_idx_r     <= idx_r;
        best_id_r      <= rd_id;
        best_arr_r     <= rd_arr;
        best_burst_r   <= burst_r[idx_r];
        best_pri_r     <= rd_pri;
        best_rem_r     <= rem_r[idx_r];
        best_first_r   <= first_r[idx_r];
        best_started_r <= started_r[idx_r];
      end
      if (is_future && (!fut_vld_r || (rd_arr < fut_min_r))) begin
        fut_min_r <= rd_arr;
      end
    end
    if (ctl.exec && best_vld_r) begin
      rem_r[best_idx_r] <= rem_left;
      best_rem_r        <= rem_left;
      if (!best_started_r) begin
        first_r[best_idx_r] <= time_r;
        best_first_r        <= time_r;
      end
    end
    if (ctl.emit) begin
      out_data_r.done_id         <= best_id_r;
      out_data_r.first_start     <= best_first_r;
      out_data_r.completion_time <= time_r;
      out_data_r.turnaround      <= tat;
      out_data_r.wait_time       <= wt;
      out_data_r.last            <= sts.last_rec;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/preemptive_priority_scheduler.sv
// top level of the preemptive priority scheduler
// depends on pps_pkg, pps_ctrl and pps_dpath
//
// usage
//   input channel (in_valid / in_ready / in_data): command 0 loads one task
//   entry (id, arrival, burst, priority) into the next free slot of a
//   16-entry table; loads into a full table are dropped. command 1 runs
//   the schedule over the loaded tasks; its other fields are ignored.
//   result channel (out_valid / out_ready / out_data): one record per
//   finished task, in completion order; the last record of a run has last
//   set, after which the table is empty again.
//   timing: loads are accepted back to back while idle. a run is a sequence of
//   scheduling steps; each step scans the table one slot per cycle through
//   a single read port, then advances the clock, and emits a record when a
//   task finishes. there are at most 2n steps for n loaded tasks, and a run
//   pauses before an emit while the receiver stalls. a run on an empty table
//   emits nothing.
//   in_ready is low for the whole run. a result waits in the output
//   register while out_ready is low; the scheduler holds before its next
//   record until that transfer completes.
//   reset (rst_n low, synchronous) empties the table and the output
//   register; in_ready rises in the cycle after reset is released.
`default_nettype none

module preemptive_priority_scheduler (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pps_pkg::pps_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pps_pkg::pps_out_t      out_data
);

  pps_pkg::pps_ctl_t ctl;
  pps_pkg::pps_sts_t sts;

  // sequencing of load, scan, clock advance and emit
  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .command  (in_data.command),
    .sts      (sts),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // task table, candidate selection, tick counter and result register
  pps_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a record is never written over one still waiting for its transfer
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> sts.out_free)
    else $error("emit while result register busy");

  // a table write only happens on an accepted input transfer
  a_load_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> (in_valid && in_ready))
    else $error("table load without transfer");

  // an idle jump always has a pending arrival to jump to
  a_idle_target: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && !sts.found) |-> sts.has_future)
    else $error("idle step with no pending arrival");

  // after the last record the block is ready for new loads
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && sts.last_rec) |=> (in_ready && sts.count_zero))
    else $error("not idle after last record");
`endif

endmodule

`default_nettype wire

### bench/tb_top.sv
// testbench of the preemptive priority scheduler: directed and random task tables
// are loaded and run, and every completion record is checked against a predictor
// depends on pps_pkg and preemptive_priority_scheduler
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transfer before giving up
  localparam int TAIL_CYCLES    = 100;   // quiet time after the last record
  localparam int IDLE_PCT       = 31;    // chance of a gap cycle on either side

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  pps_pkg::pps_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  pps_pkg::pps_out_t out_data;

  // predictor copy of the task table
  logic [pps_pkg::ID_W-1:0]  tbl_id      [pps_pkg::MAX_TASKS];
  int unsigned               tbl_arrival [pps_pkg::MAX_TASKS];
  int unsigned               tbl_burst   [pps_pkg::MAX_TASKS];
  logic [pps_pkg::PRI_W-1:0] tbl_pri     [pps_pkg::MAX_TASKS];
  int                        tbl_count;

  // completion records still owed by the block, oldest first
  pps_pkg::pps_out_t pending_completions[$];

  int error_count;
  int quiet_cycles;
  bit steady_mode;  // when set, neither side inserts gaps

  preemptive_priority_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // true when slot a wins over slot b; equal keys fall back to load order
  function automatic bit runs_first(input int a, input int b);
    if (tbl_pri[a] != tbl_pri[b]) return tbl_pri[a] < tbl_pri[b];
    if (tbl_arrival[a] != tbl_arrival[b]) return tbl_arrival[a] < tbl_arrival[b];
    return tbl_id[a] < tbl_id[b];
  endfunction

  // applies one accepted command to the table and queues the records it causes
  function automatic void apply_command(input pps_pkg::pps_in_t item);
    bit                finished_slot [pps_pkg::MAX_TASKS];
    bit                begun         [pps_pkg::MAX_TASKS];
    int unsigned       remaining     [pps_pkg::MAX_TASKS];
    int unsigned       first_tick    [pps_pkg::MAX_TASKS];
    int unsigned       now;
    int unsigned       slice;
    int unsigned       next_arr;
    int unsigned       tat;
    int                best;
    int                n;
    int                finished;
    pps_pkg::pps_out_t rec;
    if (item.command == pps_pkg::CMD_LOAD) begin
      // a full table drops the load
      if (tbl_count < pps_pkg::MAX_TASKS) begin
        tbl_id[tbl_count]      = item.task_id;
        tbl_arrival[tbl_count] = 32'(item.arrival_time);
        tbl_burst[tbl_count]   = 32'(item.burst_length);
        tbl_pri[tbl_count]     = item.priority_level;
        tbl_count++;
      end
      return;
    end
    n = tbl_count;
    if (n == 0) return;
    for (int i = 0; i < n; i++) begin
      finished_slot[i] = 1'b0;
      begun[i]         = 1'b0;
      remaining[i]     = tbl_burst[i];
      first_tick[i]    = 0;
    end
    now      = 0;
    finished = 0;
    while (finished < n) begin
      // pick the most urgent arrived task
      best = -1;
      for (int i = 0; i < n; i++) begin
        if (!finished_slot[i] && tbl_arrival[i] <= now && (best < 0 || runs_first(i, best)))
          best = i;
      end
      if (best < 0) begin
        // processor idle: skip to the next arrival
        next_arr = '1;
        for (int i = 0; i < n; i++) begin
          if (!finished_slot[i] && tbl_arrival[i] < next_arr) next_arr = tbl_arrival[i];
        end
        now = next_arr;
      end else begin
        if (!begun[best]) begin
          begun[best]      = 1'b1;
          first_tick[best] = now;
        end
        // run until done or until the next arrival could preempt
        slice = remaining[best];
        for (int i = 0; i < n; i++) begin
          if (!finished_slot[i] && tbl_arrival[i] > now && tbl_arrival[i] - now < slice)
            slice = tbl_arrival[i] - now;
        end
        now             += slice;
        remaining[best] -= slice;
        if (remaining[best] == 0) begin
          finished_slot[best] = 1'b1;
          finished++;
          tat                 = now - tbl_arrival[best];
          rec.done_id         = tbl_id[best];
          rec.first_start     = pps_pkg::TIME_W'(first_tick[best]);
          rec.completion_time = pps_pkg::TIME_W'(now);
          rec.turnaround      = pps_pkg::TIME_W'(tat);
          rec.wait_time       = pps_pkg::TIME_W'(tat - tbl_burst[best]);
          rec.last            = (finished == n);
          pending_completions.insert(pending_completions.size(), rec);
        end
      end
    end
    tbl_count = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_record(input pps_pkg::pps_out_t got);
    pps_pkg::pps_out_t want;
    if (pending_completions.size() == 0) begin
      report_error($sformatf("record for task %0d with none expected", got.done_id));
      return;
    end
    want = pending_completions.pop_front();
    if (got.done_id !== want.done_id)
      report_error($sformatf("done_id %0d, expected %0d", got.done_id, want.done_id));
    if (got.first_start !== want.first_start)
      report_error($sformatf("task %0d first_start %0d, expected %0d",
                             want.done_id, got.first_start, want.first_start));
    if (got.completion_time !== want.completion_time)
      report_error($sformatf("task %0d completion_time %0d, expected %0d",
                             want.done_id, got.completion_time, want.completion_time));
    if (got.turnaround !== want.turnaround)
      report_error($sformatf("task %0d turnaround %0d, expected %0d",
                             want.done_id, got.turnaround, want.turnaround));
    if (got.wait_time !== want.wait_time)
      report_error($sformatf("task %0d wait_time %0d, expected %0d",
                             want.done_id, got.wait_time, want.wait_time));
    if (got.last !== want.last)
      report_error($sformatf("task %0d last %0b, expected %0b",
                             want.done_id, got.last, want.last));
  endtask

  // result transfers are sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_record(out_data);
  end

  // receiver: random stalls unless in a steady stretch
  always @(negedge clk) begin
    out_ready <= steady_mode || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog: a long stretch with no transfer at all means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // random bits for every field
  function automatic pps_pkg::pps_in_t random_payload();
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    return junk[$bits(pps_pkg::pps_in_t)-1:0];
  endfunction

  function automatic pps_pkg::pps_in_t load_item(input int id, input int arr, input int burst,
                                                 input int pri);
    pps_pkg::pps_in_t item;
    item.command        = pps_pkg::CMD_LOAD;
    item.task_id        = pps_pkg::ID_W'(id);
    item.arrival_time   = pps_pkg::ARR_W'(arr);
    item.burst_length   = pps_pkg::BURST_W'(burst);
    item.priority_level = pps_pkg::PRI_W'(pri);
    return item;
  endfunction

  // run command; the other fields carry junk the block must ignore
  function automatic pps_pkg::pps_in_t run_item();
    pps_pkg::pps_in_t item;
    item         = random_payload();
    item.command = pps_pkg::CMD_RUN;
    return item;
  endfunction

  // one transfer on the input channel; called and returns at a falling edge,
  // valid stays high into the next item when there is no gap
  task automatic send_item(input pps_pkg::pps_in_t item);
    if (!steady_mode) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        in_data  <= random_payload();  // payload is don't care while valid is low
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    apply_command(item);
    @(negedge clk);
  endtask

  // sender holds off until every owed record has been taken
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_completions.size() != 0) @(negedge clk);
  endtask

  // one random table and its run; mostly small tables, now and then an overflow
  task automatic send_random_batch(output int sent);
    int n;
    int dup_ids;
    int id;
    int arr;
    int burst;
    int pri;
    n       = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
    dup_ids = ($urandom_range(0, 3) == 0);
    sent    = 0;
    for (int k = 0; k < n; k++) begin
      id  = dup_ids ? $urandom_range(0, 3) : $urandom_range(0, 255);
      arr = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 30) : $urandom_range(0, 65535);
      case ($urandom_range(0, 19))
        0:       burst = 0;
        1, 2, 3,
        4, 5:    burst = $urandom_range(1, 65535);
        default: burst = $urandom_range(1, 12);
      endcase
      pri = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
      send_item(load_item(id, arr, burst, pri));
      sent++;
    end
    send_item(run_item());
    sent++;
    // noise: a second run finds the table already empty
    if ($urandom_range(0, 7) == 0) begin
      send_item(run_item());
      sent++;
    end
  endtask

  task automatic test_empty_run();
    send_item(run_item());
  endtask

  // extremes of id, arrival and priority, and the largest burst, in a single run
  task automatic test_field_extremes();
    send_item(load_item(255, 65535, 65535, 255));
    send_item(load_item(0, 0, 1, 0));
    send_item(load_item(8'h5a, 16'h8000, 16'h7fff, 8'h80));
    send_item(run_item());
  endtask

  // preemption, tie breaks on id and load order, zero burst
  task automatic test_ties_and_preemption();
    send_item(load_item(7, 0, 10, 5));   // long low-urgency task, gets preempted
    send_item(load_item(3, 4, 3, 1));
    send_item(load_item(3, 4, 0, 1));    // same keys as above, loses on load order
    send_item(load_item(2, 4, 2, 1));    // lower id wins the tie
    send_item(run_item());
  endtask

  // 17 loads into a 16-entry table; the 16 kept are late and long to hit the top time bits
  task automatic test_table_full();
    for (int k = 0; k < pps_pkg::MAX_TASKS; k++)
      send_item(load_item(k, 65535, 65535, $urandom_range(0, 255)));
    send_item(load_item(8'hee, 0, 1, 0));  // dropped
    send_item(run_item());
  endtask

  task automatic test_random_mix(input int target);
    int total;
    int sent;
    total = 0;
    while (total < target) begin
      send_random_batch(sent);
      total += sent;
    end
  endtask

  // no gaps on either side
  task automatic test_back_to_back(input int target);
    steady_mode = 1'b1;
    test_random_mix(target);
    steady_mode = 1'b0;
  endtask

  // sender waits for all owed records before the next table
  task automatic test_drain_pause();
    int sent;
    send_random_batch(sent);
    hold_until_drained();
    send_random_batch(sent);
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    tbl_count   = 0;
    error_count = 0;
    quiet_cycles = 0;
    steady_mode = 1'b0;
    for (int i = 0; i < pps_pkg::MAX_TASKS; i++) begin
      tbl_id[i]      = '0;
      tbl_arrival[i] = '0;
      tbl_burst[i]   = '0;
      tbl_pri[i]     = '0;
    end

    // synchronous reset
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_run();
    test_field_extremes();
    test_ties_and_preemption();
    test_table_full();
    test_random_mix(40);
    test_back_to_back(30);
    test_drain_pause();
    test_random_mix(25);

    // wait for the last records, then a quiet tail
    in_valid <= 1'b0;
    while (pending_completions.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_completions.size() != 0)
      report_error($sformatf("%0d records never arrived", pending_completions.size()));

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/pps_pkg.sv
hw/rtl/pps_ctrl.sv
hw/rtl/pps_dpath.sv
hw/rtl/preemptive_priority_scheduler.sv
bench/tb_top.sv
